FILE: rtl/sff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_pkg: shared definitions for the stereo FIR filter
// Filter length, coefficient format, accumulator sizing, rounding and
// saturation constants, the sequencer states and the MAC control group.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int HALF_ORDER     = 32;
  localparam int COEF_FRAC_BITS = 15;
  localparam int NUM_TAPS       = 2 * HALF_ORDER + 1;
  localparam int ADDR_W         = $clog2(NUM_TAPS);

  // Field widths of one request and one result.
  localparam int IDX_W  = 7;
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;

  // A product fits in PROD_W bits; the sum of NUM_TAPS products needs ADDR_W more.
  localparam int ACC_W = PROD_W + ADDR_W;

  // Rounding offsets: ties away from zero.
  localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_NEG = RND_POS - ACC_W'(1);

  // Saturation limits of a 16-bit result.
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

  // Request kinds carried in tuser.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // Coefficient channel select.
  localparam logic CHAN_LEFT  = 1'b0;
  localparam logic CHAN_RIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;    // zero the accumulator
    logic prod_en;  // capture the product of the memory outputs
    logic acc_en;   // add the captured product
  } mac_ctl_t;

endpackage

FILE: rtl/stereo_fir_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fir_filter: two direct-form FIR filters, left and right channel
// Sample history sits in a circular buffer RAM, coefficients in one RAM per
// channel; one MAC per channel walks all taps.
// ----------------------------------------------------------------------------
// A sample result follows the tap walk, the read, product and sum stages and
// the hand-off; the walk reads one history word and one coefficient per channel
// per cycle. Requests are taken only while idle: one coefficient load a cycle,
// and a new sample once the last result is handed off. The output register
// lets the next request in while a result waits. Reset: a clearing
// pass zeroes all history and coefficients; no request is accepted during it.
module stereo_fir_filter
  import sff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coef_channel[0], coef_index[7:1], coef_value[23:8], left_sample[39:24],
  // right_sample[55:40]
  input  logic [55:0] s_axis_tdata,
  // mode[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out[15:0], right_out[31:16]
  output logic [31:0] m_axis_tdata
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_TAPS - 1);

  // Request fields.
  logic                     mode;
  logic                     coef_channel;
  logic [IDX_W-1:0]         coef_index;
  logic signed [DATA_W-1:0] coef_value;
  logic signed [DATA_W-1:0] left_sample;
  logic signed [DATA_W-1:0] right_sample;

  assign mode         = s_axis_tuser[0];
  assign coef_channel = s_axis_tdata[0];
  assign coef_index   = s_axis_tdata[7:1];
  assign coef_value   = s_axis_tdata[23:8];
  assign left_sample  = s_axis_tdata[39:24];
  assign right_sample = s_axis_tdata[55:40];

  state_t state;
  state_t state_next;

  logic              accept;
  logic              sample_acc;
  logic              load_acc;
  logic              load_ok;
  logic              out_load;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] haddr;
  logic              rd_v;
  logic              rd_last;
  logic              prod_v;
  logic              prod_last;
  logic              acc_done;

  // Memory ports.
  logic                hist_we;
  logic [ADDR_W-1:0]   hist_addr;
  logic [2*DATA_W-1:0] hist_wdata;
  logic [2*DATA_W-1:0] hist_rdata;
  logic                ltap_we;
  logic                rtap_we;
  logic [ADDR_W-1:0]   tap_addr;
  logic [DATA_W-1:0]   tap_wdata;
  logic [DATA_W-1:0]   ltap_rdata;
  logic [DATA_W-1:0]   rtap_rdata;

  mac_ctl_t                 mac_ctl;
  logic signed [DATA_W-1:0] left_res;
  logic signed [DATA_W-1:0] right_res;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample_acc    = accept && (mode == MODE_SAMPLE);
  assign load_acc      = accept && (mode == MODE_LOAD);
  assign load_ok       = (32'(coef_index) < NUM_TAPS);
  assign out_load      = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: clearing pass, idle, tap walk, pipeline drain, result hand-off.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (sample_acc) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == LAST_ADDR) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (acc_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Tap counter, write pointer and history read address.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= '0;
    end else begin
      if (state == ST_CLEAR || state == ST_RUN) begin
        cnt <= (cnt == LAST_ADDR) ? '0 : cnt + 1'b1;
      end
      if (sample_acc) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
      end
    end
  end

  // The newest sample sits at the old write pointer; older ones lie below it.
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      haddr <= wp;
    end else if (state == ST_RUN) begin
      haddr <= (haddr == '0) ? LAST_ADDR : haddr - 1'b1;
    end
  end

  // Valid and last flags that follow the read, product and sum stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
      acc_done  <= 1'b0;
    end else begin
      rd_v      <= (state == ST_RUN);
      rd_last   <= (state == ST_RUN) && (cnt == LAST_ADDR);
      prod_v    <= rd_v;
      prod_last <= rd_last;
      acc_done  <= prod_last;
    end
  end

  // Memory address and write selection.
  always_comb begin
    hist_we    = 1'b0;
    ltap_we    = 1'b0;
    rtap_we    = 1'b0;
    hist_addr  = haddr;
    tap_addr   = cnt;
    hist_wdata = {right_sample, left_sample};
    tap_wdata  = coef_value;
    unique case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        ltap_we    = 1'b1;
        rtap_we    = 1'b1;
        hist_addr  = cnt;
        hist_wdata = '0;
        tap_wdata  = '0;
      end
      ST_IDLE: begin
        hist_we   = sample_acc;
        ltap_we   = load_acc && load_ok && (coef_channel == CHAN_LEFT);
        rtap_we   = load_acc && load_ok && (coef_channel == CHAN_RIGHT);
        hist_addr = wp;
        tap_addr  = ADDR_W'(coef_index);
      end
      ST_RUN, ST_DRAIN, ST_FINISH: begin
        hist_we = 1'b0;
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  sff_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(NUM_TAPS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .addr (hist_addr),
    .wdata(hist_wdata),
    .rdata(hist_rdata)
  );

  sff_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_TAPS)
  ) u_ltap_ram (
    .clk  (clk),
    .we   (ltap_we),
    .addr (tap_addr),
    .wdata(tap_wdata),
    .rdata(ltap_rdata)
  );

  sff_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_TAPS)
  ) u_rtap_ram (
    .clk  (clk),
    .we   (rtap_we),
    .addr (tap_addr),
    .wdata(tap_wdata),
    .rdata(rtap_rdata)
  );

  // MAC control shared by both channels.
  assign mac_ctl.clear   = sample_acc;
  assign mac_ctl.prod_en = rd_v;
  assign mac_ctl.acc_en  = prod_v;

  sff_mac u_mac_left (
    .clk   (clk),
    .ctl   (mac_ctl),
    .tap   (ltap_rdata),
    .sample(hist_rdata[DATA_W-1:0]),
    .result(left_res)
  );

  sff_mac u_mac_right (
    .clk   (clk),
    .ctl   (mac_ctl),
    .tap   (rtap_rdata),
    .sample(hist_rdata[2*DATA_W-1:DATA_W]),
    .result(right_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {right_res, left_res};
    end
  end

  // A sample request starts the tap walk at the first tap.
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    sample_acc |=> (state == ST_RUN) && (cnt == '0))
    else $error("tap walk did not start at the first tap");

  // The history memory is never written while a walk reads it.
  a_no_hist_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_DRAIN) |-> !hist_we)
    else $error("history written during a tap walk");

  // The final sum is complete only while draining.
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> (state == ST_DRAIN))
    else $error("accumulation finished outside the drain state");

  // A new result appears only from the hand-off state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised without a finished walk");

endmodule

FILE: rtl/sff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_ram: generic single-port RAM
// One address per cycle for read and write, registered read data.
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/sff_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_mac: multiply-accumulate datapath of one channel
// Registered product, wide accumulator, and round-half-away-from-zero with
// saturation of the final sum to 16 bits.
// ----------------------------------------------------------------------------
module sff_mac
  import sff_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] tap,
  input  logic signed [DATA_W-1:0] sample,
  output logic signed [DATA_W-1:0] result
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  scaled;

  // Product stage, then accumulate.
  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod <= tap * sample;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Negative sums take one less offset so that ties round away from zero.
  always_comb begin
    rounded = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
    scaled  = rounded >>> COEF_FRAC_BITS;
    if (scaled > SAT_MAX) begin
      result = SAT_MAX[DATA_W-1:0];
    end else if (scaled < SAT_MIN) begin
      result = SAT_MIN[DATA_W-1:0];
    end else begin
      result = scaled[DATA_W-1:0];
    end
  end

endmodule
